// ===== rtl/core/chb_pkg.sv =====
`timescale 1ns / 1ps
package chb_pkg;

  localparam int MAX_SYMBOLS     = 256;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int NUM_LENGTHS     = 16;

  localparam logic [16:0] CODE_SAT = 17'h1FFFF;
  localparam logic [8:0]  EMIT_SAT = 9'd511;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [4:0]  code_length;
    logic [15:0] code;
    logic        last;
    logic        error;
  } out_item_t;

  // lowest used length above 'from', zero when there is none
  function automatic logic [4:0] next_used(input logic [NUM_LENGTHS-1:0] nz,
                                           input logic [4:0] from);
    logic [4:0] res;
    res = '0;
    for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
      if (nz[i] && ((5'(i) + 5'd1) > from)) begin
        res = 5'(i + 1);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/chb_in_if.sv =====
`timescale 1ns / 1ps
interface chb_in_if;
  logic               valid;
  logic               ready;
  chb_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/chb_out_if.sv =====
`timescale 1ns / 1ps
interface chb_out_if;
  logic               valid;
  logic               ready;
  chb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/chb_engine.sv =====
`timescale 1ns / 1ps
module chb_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  chb_pkg::in_item_t  item,
  output logic               res_valid,
  output chb_pkg::out_item_t res
);

  localparam int NL = chb_pkg::NUM_LENGTHS;

  logic              in_phase_r, in_phase_nxt;
  logic [3:0]        pos_r, pos_nxt;
  logic [7:0]        counts_r [NL];
  logic [7:0]        counts_nxt [NL];
  logic [NL-1:0]     nz_r, nz_nxt;
  logic [11:0]       sum_r, sum_nxt;
  logic [11:0]       rem_r, rem_nxt;
  logic [8:0]        emitted_r, emitted_nxt;
  logic [4:0]        cur_len_r, cur_len_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [16:0]       code_r, code_nxt;

  logic              start;
  logic              phase;
  logic [3:0]        pos;
  logic [4:0]        len;
  logic [4:0]        len_step;
  logic [31:0]       shifted;
  logic [11:0]       rem_dec;
  logic [7:0]        left_dec;
  logic [16:0]       code_inc;

  always_comb begin
    in_phase_nxt = in_phase_r;
    pos_nxt      = pos_r;
    counts_nxt   = counts_r;
    nz_nxt       = nz_r;
    sum_nxt      = sum_r;
    rem_nxt      = rem_r;
    emitted_nxt  = emitted_r;
    cur_len_nxt  = cur_len_r;
    left_nxt     = left_r;
    code_nxt     = code_r;
    res_valid    = 1'b0;
    res          = '0;
    len          = '0;
    len_step     = '0;
    shifted      = '0;
    rem_dec      = rem_r - 12'd1;
    left_dec     = (left_r != 8'd0) ? left_r - 8'd1 : left_r;
    code_inc     = (code_r < chb_pkg::CODE_SAT) ? code_r + 17'd1 : code_r;

    start = fire && item.start_req;
    phase = start ? 1'b0 : in_phase_r;
    pos   = start ? 4'd0 : pos_r;

    if (fire) begin
      if (!phase) begin
        counts_nxt[pos] = item.table_byte;
        nz_nxt[pos]     = |item.table_byte;
        if (pos == 4'(NL - 1)) begin
          rem_nxt      = sum_r + {4'b0, item.table_byte};
          emitted_nxt  = '0;
          code_nxt     = '0;
          len          = chb_pkg::next_used(nz_nxt, 5'd0);
          cur_len_nxt  = len;
          left_nxt     = (len != 5'd0) ? counts_nxt[4'(len - 5'd1)] : 8'd0;
          in_phase_nxt = 1'b1;
          pos_nxt      = 4'd0;
        end else begin
          sum_nxt      = (pos == 4'd0) ? {4'b0, item.table_byte}
                                       : sum_r + {4'b0, item.table_byte};
          pos_nxt      = pos + 4'd1;
          in_phase_nxt = 1'b0;
        end
      end else if (rem_r != 12'd0 && cur_len_r != 5'd0) begin
        res_valid        = 1'b1;
        res.symbol       = item.table_byte;
        res.code_length  = cur_len_r;
        res.code         = code_r[15:0];
        res.last         = (rem_r == 12'd1);
        res.error        = ((code_r >> cur_len_r) != 17'd0)
                        || (emitted_r >= 9'(chb_pkg::MAX_SYMBOLS))
                        || (cur_len_r > 5'(chb_pkg::MAX_CODE_LENGTH));

        emitted_nxt = (emitted_r < chb_pkg::EMIT_SAT) ? emitted_r + 9'd1 : emitted_r;
        rem_nxt     = rem_dec;
        code_nxt    = code_inc;
        left_nxt    = left_dec;

        // move on to the next used length, code shifts by the lengths skipped
        if (left_dec == 8'd0 && rem_dec != 12'd0) begin
          len = chb_pkg::next_used(nz_r, cur_len_r);
          if (len != 5'd0) begin
            len_step    = len - cur_len_r;
            shifted     = {15'b0, code_inc} << len_step;
            code_nxt    = (|shifted[31:17]) ? chb_pkg::CODE_SAT : shifted[16:0];
            cur_len_nxt = len;
            left_nxt    = counts_r[4'(len - 5'd1)];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_phase_r <= 1'b0;
      pos_r      <= '0;
      rem_r      <= '0;
      emitted_r  <= '0;
      cur_len_r  <= '0;
      left_r     <= '0;
      code_r     <= '0;
    end else begin
      in_phase_r <= in_phase_nxt;
      pos_r      <= pos_nxt;
      rem_r      <= rem_nxt;
      emitted_r  <= emitted_nxt;
      cur_len_r  <= cur_len_nxt;
      left_r     <= left_nxt;
      code_r     <= code_nxt;
    end
  end

  // length counts and their running sum are always written before use
  always_ff @(posedge clk) begin
    counts_r <= counts_nxt;
    nz_r     <= nz_nxt;
    sum_r    <= sum_nxt;
  end

endmodule

// ===== rtl/core/chb_out_buf.sv =====
`timescale 1ns / 1ps
module chb_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  chb_pkg::out_item_t item,
  output logic               can_take,
  chb_out_if.source          out_chan
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  chb_pkg::out_item_t main_d_r, main_d_nxt;
  chb_pkg::out_item_t skid_d_r, skid_d_nxt;
  logic               pop;

  assign pop            = main_v_r && out_chan.ready;
  assign out_chan.valid = main_v_r;
  assign out_chan.data  = main_d_r;
  assign can_take       = !skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      main_v_nxt = 1'b0;
    end
    if (skid_v_r && !main_v_nxt) begin
      main_v_nxt = 1'b1;
      main_d_nxt = skid_d_r;
      skid_v_nxt = 1'b0;
    end
    if (push) begin
      if (!main_v_nxt) begin
        main_v_nxt = 1'b1;
        main_d_nxt = item;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

// ===== rtl/core/canonical_huffman_code_builder_core.sv =====
`timescale 1ns / 1ps
// a symbol byte's result goes to out_chan through the registered output buffer
// throughput: one table byte per cycle while ready is high; count and surplus bytes give no result
// the code table state updates in the cycle of each transfer; a two-entry output
// buffer holds results, in_chan.ready drops only while both entries are full
// reset clears the phase, counters and code; stored length counts are not cleared
module canonical_huffman_code_builder_core (
  input  logic      clk,
  input  logic      rst_n,
  chb_in_if.sink    in_chan,
  chb_out_if.source out_chan
);

  logic               fire;
  logic               can_take;
  logic               res_valid;
  chb_pkg::out_item_t res;

  assign in_chan.ready = can_take;
  assign fire          = in_chan.valid && can_take;

  chb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_chan.data),
    .res_valid (res_valid),
    .res       (res)
  );

  chb_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .item     (res),
    .can_take (can_take),
    .out_chan (out_chan)
  );

endmodule

// ===== dv/canonical_huffman_code_builder_core_test.sv =====
`timescale 1ns / 1ps
module canonical_huffman_code_builder_core_test;

  localparam int RAND_ITEMS  = 1650;
  localparam int HOLD_LEN    = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    TBL_PREFIX_FREE,
    TBL_OVERFULL,
    TBL_EMPTY,
    TBL_HUGE,
    TBL_NOISE
  } table_kind_t;

  // tracks the code table state and the codes still owed by the block
  class code_table_model;
    bit                 in_symbols;
    bit [3:0]           count_pos;
    bit [7:0]           len_count [chb_pkg::NUM_LENGTHS];
    bit [11:0]          remaining;
    bit [8:0]           emitted;
    bit [4:0]           cur_len;
    bit [7:0]           left_at_len;
    bit [16:0]          code;
    chb_pkg::out_item_t pending_codes [$];
    int                 mismatches;

    function new();
      in_symbols  = 1'b0;
      count_pos   = '0;
      remaining   = '0;
      emitted     = '0;
      cur_len     = '0;
      left_at_len = '0;
      code        = '0;
      mismatches  = 0;
      foreach (len_count[i]) len_count[i] = '0;
    endfunction

    function bit [4:0] first_used_after(bit [4:0] from);
      for (int n = int'(from) + 1; n <= chb_pkg::NUM_LENGTHS; n++) begin
        if (len_count[n-1] != 0) return 5'(n);
      end
      return 5'd0;
    endfunction

    function void enter_length(bit [4:0] len);
      cur_len     = len;
      left_at_len = (len != 0) ? len_count[len-1] : 8'd0;
    endfunction

    function void note_byte(chb_pkg::in_item_t it);
      chb_pkg::out_item_t exp;
      int                 total;
      bit [4:0]           nl;
      bit [63:0]          shifted;
      bit                 flag;
      if (it.start_req) begin
        in_symbols = 1'b0;
        count_pos  = '0;
      end
      if (!in_symbols) begin
        len_count[count_pos] = it.table_byte;
        if (count_pos == 4'(chb_pkg::NUM_LENGTHS - 1)) begin
          total = 0;
          foreach (len_count[i]) total += len_count[i];
          remaining  = total[11:0];
          emitted    = '0;
          code       = '0;
          enter_length(first_used_after(5'd0));
          in_symbols = 1'b1;
          count_pos  = '0;
        end else begin
          count_pos++;
        end
        return;
      end
      // surplus bytes and empty tables produce nothing
      if (remaining == 0 || cur_len == 0) return;
      flag = (code >> cur_len) != 0;
      if (emitted >= chb_pkg::MAX_SYMBOLS) flag = 1'b1;
      if (cur_len > chb_pkg::MAX_CODE_LENGTH) flag = 1'b1;
      exp.symbol      = it.table_byte;
      exp.code_length = cur_len;
      exp.code        = code[15:0];
      exp.last        = (remaining == 1);
      exp.error       = flag;
      pending_codes.push_back(exp);
      if (emitted < chb_pkg::EMIT_SAT) emitted++;
      remaining--;
      if (code < chb_pkg::CODE_SAT) code++;
      if (left_at_len != 0) left_at_len--;
      if (left_at_len == 0 && remaining != 0) begin
        nl = first_used_after(cur_len);
        if (nl != 0) begin
          shifted = 64'(code) << (nl - cur_len);
          code    = (shifted > 64'(chb_pkg::CODE_SAT)) ? chb_pkg::CODE_SAT : shifted[16:0];
          enter_length(nl);
        end
      end
    endfunction

    function void check_code(chb_pkg::out_item_t got);
      chb_pkg::out_item_t exp;
      bit                 bad;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected code: sym %0h len %0d code %0h last %0b err %0b",
                   got.symbol, got.code_length, got.code, got.last, got.error);
        return;
      end
      exp = pending_codes.pop_front();
      bad = (got.symbol !== exp.symbol) || (got.code_length !== exp.code_length) ||
            (got.code !== exp.code) || (got.last !== exp.last) ||
            (got.error !== exp.error);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("code mismatch: exp sym %0h len %0d code %0h last %0b err %0b",
                   exp.symbol, exp.code_length, exp.code, exp.last, exp.error);
          $display("               got sym %0h len %0d code %0h last %0b err %0b",
                   got.symbol, got.code_length, got.code, got.last, got.error);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  chb_in_if  in_chan ();
  chb_out_if out_chan ();

  canonical_huffman_code_builder_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  code_table_model codes;

  bit [7:0] tbl_counts [chb_pkg::NUM_LENGTHS];
  int       bytes_sent;
  bit       tx_steady;
  bit       hold_req;
  int       hold_cycles;
  int       rx_gap;
  int       rx_steady;
  int       rx_roll;

  always #1 clk = ~clk;

  // transfers are noted and checked at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) codes.check_code(out_chan.data);
      if (in_chan.valid && in_chan.ready) codes.note_byte(in_chan.data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, steady stretches and requested long hold-offs
  initial begin
    out_chan.ready = 1'b0;
    hold_cycles    = 0;
    rx_gap         = 0;
    rx_steady      = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_chan.ready = 1'b0;
        hold_cycles--;
      end else if (hold_req) begin
        hold_req       = 1'b0;
        hold_cycles    = HOLD_LEN - 1;
        out_chan.ready = 1'b0;
      end else if (rx_gap != 0) begin
        out_chan.ready = 1'b0;
        rx_gap--;
      end else if (rx_steady != 0) begin
        out_chan.ready = 1'b1;
        rx_steady--;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 70) begin
          out_chan.ready = 1'b1;
        end else if (rx_roll < 92) begin
          out_chan.ready = 1'b0;
          rx_gap         = $urandom_range(0, 2);
        end else if (rx_roll < 97) begin
          out_chan.ready = 1'b0;
          rx_gap         = $urandom_range(10, 40);
        end else begin
          out_chan.ready = 1'b1;
          rx_steady      = $urandom_range(50, 150);
        end
      end
    end
  end

  function automatic int tx_gap();
    int roll;
    if (tx_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit s);
    int gap;
    gap = tx_gap();
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
    @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.data  = '{table_byte: b, start_req: s};
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic wait_all_codes();
    while (codes.pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic send_table(input table_kind_t kind);
    int total;
    int nsym;
    int ncount;
    int cap;
    int c;
    int a;
    int b;
    foreach (tbl_counts[i]) tbl_counts[i] = '0;
    tx_steady = ($urandom_range(0, 3) == 0);
    case (kind)
      TBL_PREFIX_FREE: begin
        // counts that respect the code space at every length
        cap = 2;
        for (int i = 0; i < chb_pkg::NUM_LENGTHS; i++) begin
          c = 0;
          if (cap > 0 && $urandom_range(0, 2) != 0)
            c = $urandom_range(0, (cap < 4) ? cap : 4);
          tbl_counts[i] = 8'(c);
          cap = (cap - c) * 2;
          if (cap > 512) cap = 512;
        end
      end
      TBL_OVERFULL: begin
        for (int i = 0; i < chb_pkg::NUM_LENGTHS; i++)
          if ($urandom_range(0, 2) == 0) tbl_counts[i] = 8'($urandom_range(1, 8));
      end
      TBL_HUGE: begin
        // more than the symbol limit, one length at the count extreme
        for (int i = 0; i < chb_pkg::NUM_LENGTHS; i++)
          tbl_counts[i] = 8'($urandom_range(0, 2));
        a = $urandom_range(8, 15);
        b = (a + 1 + $urandom_range(0, 14)) % chb_pkg::NUM_LENGTHS;
        tbl_counts[a] = 8'd255;
        tbl_counts[b] = 8'($urandom_range(10, 30));
      end
      TBL_NOISE: begin
        c = $urandom_range(1, 8);
        repeat (c) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        return;
      end
      default: ;
    endcase
    total = 0;
    foreach (tbl_counts[i]) total += tbl_counts[i];
    ncount = chb_pkg::NUM_LENGTHS;
    if (kind != TBL_HUGE && $urandom_range(0, 15) == 0) ncount = $urandom_range(1, 15);
    for (int i = 0; i < ncount; i++) send_byte(tbl_counts[i], i == 0);
    if (ncount < chb_pkg::NUM_LENGTHS) return;
    nsym = total;
    if (kind == TBL_EMPTY)
      nsym = $urandom_range(0, 3);
    else if (kind != TBL_HUGE && $urandom_range(0, 7) == 0)
      nsym = $urandom_range(0, total);
    else if ($urandom_range(0, 2) == 0)
      nsym = total + $urandom_range(1, 3);
    if (kind == TBL_HUGE || $urandom_range(0, 9) == 0) begin
      // keep offering symbols while the result side holds off
      tx_steady = 1'b1;
      hold_req  = 1'b1;
    end
    repeat (nsym) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int          rand_start;
    int          roll;
    table_kind_t kind;
    codes         = new();
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    bytes_sent    = 0;
    tx_steady     = 1'b0;
    hold_req      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // counts taken without a start after reset, longest code length, surplus byte
    foreach (tbl_counts[i]) tbl_counts[i] = '0;
    tbl_counts[0]  = 8'd1;
    tbl_counts[2]  = 8'd2;
    tbl_counts[15] = 8'd1;
    for (int i = 0; i < chb_pkg::NUM_LENGTHS; i++) send_byte(tbl_counts[i], 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h33, 1'b0);
    // a table cut off in its count phase by the next start
    send_byte(8'd2, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b0);

    rand_start = bytes_sent;
    send_table(TBL_EMPTY);
    send_table(TBL_OVERFULL);
    send_table(TBL_HUGE);
    wait_all_codes();
    while (bytes_sent - rand_start < RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) kind = TBL_PREFIX_FREE;
      else if (roll < 78) kind = TBL_OVERFULL;
      else if (roll < 88) kind = TBL_EMPTY;
      else if (roll < 98) kind = TBL_NOISE;
      else kind = TBL_HUGE;
      send_table(kind);
      if ($urandom_range(0, 7) == 0) wait_all_codes();
    end

    @(negedge clk);
    in_chan.valid = 1'b0;
    wait_all_codes();
    repeat (8) @(posedge clk);
    if (codes.mismatches == 0 && codes.pending_codes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
